@@ sv/ccs_pkg.sv @@
// Package for the categorical CDF sampler: payload and control structs,
// command and state encodings, register map and fixed-point constants.
// Used by the top level, ccs_cfg, ccs_lcg and ccs_chk; depends on nothing.
`default_nettype none

package ccs_pkg;

  localparam int PROB_W  = 33;
  localparam int CUM_W   = 37;
  localparam int SEED_W  = 48;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 4;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 64;
  localparam int TBL_W   = CUM_W + COL_W;

  localparam logic [34:0]       LCG_MUL  = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_ADD  = 48'hB;
  localparam logic [SEED_W-1:0] SEED_RST = 48'h1234ABCD330E;
  localparam logic [PROB_W-1:0] THR_RST  = 33'd43;
  localparam logic [PROB_W-1:0] TOL_RST  = 33'd43;
  localparam logic [CUM_W-1:0]  ONE_FIX  = 37'h0100000000;
  localparam logic [CUM_W-1:0]  CUM_MAX  = 37'h1FFFFFFFFF;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_THR  = 2'd1;
  localparam logic [1:0] REG_TOL  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SAMPLE  = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DRAW   = 2'd2,
    CMD_RESEED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_TOT,
    S_GEN,
    S_SRCH,
    S_OUT
  } fsm_t;

  typedef struct packed {
    cmd_t              command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [PROB_W-1:0] probability;
  } in_data_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [COL_W-1:0] sample_column;
  } out_data_t;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [PROB_W-1:0] skip_threshold;
    logic [PROB_W-1:0] sum_tolerance;
  } cfg_regs_t;

  typedef struct packed {
    logic load;
    logic step;
  } lcg_ctl_t;

  typedef struct packed {
    logic              done;
    logic [SEED_W-1:0] state;
  } lcg_sts_t;

endpackage

`default_nettype wire

@@ sv/categorical_cdf_sampler_top.sv @@
// Categorical sampler keeping a compacted cumulative probability table per
// row. Depends on ccs_pkg, ccs_ram, ccs_cfg and ccs_lcg.
//
// Usage: commands enter on the in_ channel (in_valid, in_stall, in_data) and
// each produces exactly one result beat on the out_ channel (out_valid,
// out_stall, out_data). A beat moves at a clock edge where valid is high and
// stall is low. Commands are processed one at a time; in_stall is high while
// a command is in progress.
// Clear, reseed, an out-of-range draw and a skipped or out-of-range append
// go straight to the output register. An append reads the row count, then,
// unless the row is empty or full, its last entry, and writes. A draw reads
// the row count, then the last entry to check the sum, steps the generator
// and scans the table, one entry per cycle from the table RAM.
// A new command is accepted in the cycle after the previous one reaches the
// output register, so the block holds one command at a time. The result sits
// in an output register, so a new command is accepted while the previous
// result is still stalled; a finished result waits in the block until the
// output register frees up. Reset (synchronous, rst_n low) empties every row,
// loads the generator with its default seed and restores the register
// defaults. No clearing pass is needed. Configuration is to be written
// through the APB-style port while idle; the block does not enforce this.
`default_nettype none

module categorical_cdf_sampler_top #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ccs_pkg::in_data_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ccs_pkg::out_data_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ccs_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [ccs_pkg::CFG_DW-1:0]  pwdata,
  output logic      [ccs_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CW = $clog2(COLS + 1);
  localparam int TD = ROWS * COLS;
  localparam int AW = (TD > 1) ? $clog2(TD) : 1;
  localparam int PW = ccs_pkg::PROB_W;
  localparam int UW = ccs_pkg::CUM_W;
  localparam int KW = ccs_pkg::COL_W;

  ccs_pkg::cfg_regs_t regs;
  ccs_pkg::lcg_ctl_t  lcg_ctl;
  ccs_pkg::lcg_sts_t  lcg_sts;

  ccs_pkg::fsm_t      state_r, state_nxt;
  ccs_pkg::cmd_t      cmd_r;
  logic [RW-1:0]      row_r;
  logic [KW-1:0]      col_r;
  logic [PW-1:0]      prob_r;
  logic               vld_q_r;
  logic [CW-1:0]      n_r, n_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  ccs_pkg::out_data_t res_r, res_nxt;
  logic [ROWS-1:0]    vld_r, vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  ccs_pkg::out_data_t out_data_r;

  logic               in_acc;
  logic               row_ok;
  logic               skip;
  logic [RW-1:0]      in_row;
  logic [CW-1:0]      cnt_n;
  logic [CW-1:0]      cnt_rdata;
  logic               cnt_we;
  logic [CW-1:0]      cnt_wdata;
  logic [AW-1:0]      base;
  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [ccs_pkg::TBL_W-1:0] tbl_wdata;
  logic [AW-1:0]      tbl_raddr;
  logic [ccs_pkg::TBL_W-1:0] tbl_rdata;
  logic [UW-1:0]      rd_cum;
  logic [KW-1:0]      rd_col;
  logic [UW:0]        app_sum;
  logic [UW-1:0]      app_cum;
  logic [UW-1:0]      sum_dev;
  logic               sum_ok;
  logic [31:0]        u;
  logic               srch_adv;
  logic               out_free;
  logic               out_load;

  ccs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  ccs_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lcg_ctl),
    .seed  (regs.seed),
    .sts   (lcg_sts)
  );

  ccs_ram #(.WIDTH(CW), .DEPTH(ROWS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (row_r),
    .wdata (cnt_wdata),
    .raddr (in_row),
    .rdata (cnt_rdata)
  );

  ccs_ram #(.WIDTH(ccs_pkg::TBL_W), .DEPTH(TD)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign in_stall  = (state_r != ccs_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_row    = RW'(in_data.row);
  assign row_ok    = (9'(in_data.row) < 9'(ROWS));
  assign skip      = (in_data.probability < regs.skip_threshold);
  assign cnt_n     = vld_q_r ? cnt_rdata : '0;
  assign base      = AW'(row_r) * AW'(COLS);
  assign rd_cum    = tbl_rdata[ccs_pkg::TBL_W-1:KW];
  assign rd_col    = tbl_rdata[KW-1:0];
  assign app_sum   = {1'b0, rd_cum} + (UW+1)'(prob_r);
  assign app_cum   = app_sum[UW] ? ccs_pkg::CUM_MAX : app_sum[UW-1:0];
  assign sum_dev   = (rd_cum >= ccs_pkg::ONE_FIX) ? (rd_cum - ccs_pkg::ONE_FIX)
                                                  : (ccs_pkg::ONE_FIX - rd_cum);
  assign sum_ok    = !(sum_dev > UW'(regs.sum_tolerance));
  assign u         = lcg_sts.state[47:16];
  assign srch_adv  = ((CW'(idx_r) + CW'(1)) < n_r) && (rd_cum < UW'(u));
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ccs_pkg::S_OUT) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccs_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            ccs_pkg::CMD_APPEND: begin
              state_nxt = (row_ok && !skip) ? ccs_pkg::S_CNT : ccs_pkg::S_OUT;
            end
            ccs_pkg::CMD_DRAW: begin
              state_nxt = row_ok ? ccs_pkg::S_CNT : ccs_pkg::S_OUT;
            end
            default: state_nxt = ccs_pkg::S_OUT;
          endcase
        end
      end
      ccs_pkg::S_CNT: begin
        if (cmd_r == ccs_pkg::CMD_APPEND) begin
          state_nxt = (cnt_n >= CW'(COLS) || cnt_n == '0) ? ccs_pkg::S_OUT
                                                          : ccs_pkg::S_TOT;
        end else begin
          state_nxt = (cnt_n == '0) ? ccs_pkg::S_OUT : ccs_pkg::S_TOT;
        end
      end
      ccs_pkg::S_TOT: begin
        state_nxt = (cmd_r == ccs_pkg::CMD_DRAW && sum_ok) ? ccs_pkg::S_GEN
                                                          : ccs_pkg::S_OUT;
      end
      ccs_pkg::S_GEN: begin
        if (lcg_sts.done) begin
          state_nxt = ccs_pkg::S_SRCH;
        end
      end
      ccs_pkg::S_SRCH: begin
        if (!srch_adv) begin
          state_nxt = ccs_pkg::S_OUT;
        end
      end
      ccs_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = ccs_pkg::S_IDLE;
        end
      end
      default: state_nxt = ccs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    res_nxt   = res_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    vld_nxt   = vld_r;
    cnt_we    = 1'b0;
    cnt_wdata = n_r + CW'(1);
    tbl_we    = 1'b0;
    tbl_waddr = base + AW'(IW'(n_r));
    tbl_wdata = {app_cum, col_r};
    tbl_raddr = base + AW'(idx_r);
    lcg_ctl   = '0;
    case (state_r)
      ccs_pkg::S_IDLE: begin
        if (in_acc) begin
          res_nxt.status        = ccs_pkg::ST_DONE;
          res_nxt.sample_column = '0;
          idx_nxt               = '0;
          case (in_data.command)
            ccs_pkg::CMD_CLEAR: begin
              if (row_ok) begin
                vld_nxt[in_row] = 1'b0;
              end
            end
            ccs_pkg::CMD_DRAW: begin
              if (!row_ok) begin
                res_nxt.status = ccs_pkg::ST_BAD_SUM;
              end
            end
            ccs_pkg::CMD_RESEED: begin
              lcg_ctl.load = 1'b1;
            end
            default: res_nxt = res_nxt;
          endcase
        end
      end
      ccs_pkg::S_CNT: begin
        n_nxt     = cnt_n;
        tbl_raddr = base + AW'(IW'(cnt_n - CW'(1)));
        if (cmd_r == ccs_pkg::CMD_APPEND) begin
          if (cnt_n >= CW'(COLS)) begin
            res_nxt.status = ccs_pkg::ST_FULL;
          end else if (cnt_n == '0) begin
            tbl_we         = 1'b1;
            tbl_waddr      = base;
            tbl_wdata      = {UW'(prob_r), col_r};
            cnt_we         = 1'b1;
            cnt_wdata      = CW'(1);
            vld_nxt[row_r] = 1'b1;
          end
        end else if (cnt_n == '0) begin
          res_nxt.status = ccs_pkg::ST_BAD_SUM;
        end
      end
      ccs_pkg::S_TOT: begin
        if (cmd_r == ccs_pkg::CMD_APPEND) begin
          tbl_we         = 1'b1;
          cnt_we         = 1'b1;
          vld_nxt[row_r] = 1'b1;
        end else if (!sum_ok) begin
          res_nxt.status = ccs_pkg::ST_BAD_SUM;
        end else begin
          lcg_ctl.step = 1'b1;
        end
      end
      ccs_pkg::S_SRCH: begin
        if (srch_adv) begin
          idx_nxt   = idx_r + IW'(1);
          tbl_raddr = base + AW'(idx_r + IW'(1));
        end else begin
          res_nxt.status        = ccs_pkg::ST_SAMPLE;
          res_nxt.sample_column = rd_col;
        end
      end
      default: res_nxt = res_r;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccs_pkg::S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      cmd_r   <= in_data.command;
      row_r   <= in_row;
      col_r   <= in_data.column;
      prob_r  <= in_data.probability;
      vld_q_r <= row_ok && vld_r[in_row];
    end
    n_r   <= n_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

endmodule

`default_nettype wire

@@ sv/ccs_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; instanced for the cumulative table and the row counts.
`default_nettype none

module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/ccs_cfg.sv @@
// APB-style register file for seed, skip threshold and sum tolerance.
// Depends on ccs_pkg for the register map and reset values.
`default_nettype none

module ccs_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ccs_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [ccs_pkg::CFG_DW-1:0]   pwdata,
  output logic      [ccs_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output ccs_pkg::cfg_regs_t                regs
);

  ccs_pkg::cfg_regs_t regs_r;
  ccs_pkg::cfg_regs_t regs_nxt;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];
  assign regs    = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (reg_idx)
        ccs_pkg::REG_SEED: regs_nxt.seed           = pwdata[ccs_pkg::SEED_W-1:0];
        ccs_pkg::REG_THR:  regs_nxt.skip_threshold = pwdata[ccs_pkg::PROB_W-1:0];
        ccs_pkg::REG_TOL:  regs_nxt.sum_tolerance  = pwdata[ccs_pkg::PROB_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ccs_pkg::REG_SEED: prdata = ccs_pkg::CFG_DW'(regs_r.seed);
      ccs_pkg::REG_THR:  prdata = ccs_pkg::CFG_DW'(regs_r.skip_threshold);
      ccs_pkg::REG_TOL:  prdata = ccs_pkg::CFG_DW'(regs_r.sum_tolerance);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.seed           <= ccs_pkg::SEED_RST;
      regs_r.skip_threshold <= ccs_pkg::THR_RST;
      regs_r.sum_tolerance  <= ccs_pkg::TOL_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/ccs_lcg.sv @@
// 48-bit linear congruential generator. One step multiplies the state by the
// 35-bit constant in three 16-bit partial products, one per cycle unless a
// load or step cuts in; depends on ccs_pkg for constants and control structs.
`default_nettype none

module ccs_lcg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ccs_pkg::lcg_ctl_t             ctl,
  input  wire logic [ccs_pkg::SEED_W-1:0]    seed,
  output ccs_pkg::lcg_sts_t                  sts
);

  localparam int SW = ccs_pkg::SEED_W;

  logic [SW-1:0] state_r, state_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          busy_r, busy_nxt;
  logic [15:0]   chunk;
  logic [50:0]   prod;
  logic [SW-1:0] part;
  logic [SW-1:0] acc_sum;
  logic          last;

  always_comb begin
    case (ph_r)
      2'd0:    chunk = state_r[15:0];
      2'd1:    chunk = state_r[31:16];
      default: chunk = state_r[47:32];
    endcase
  end

  assign prod = 51'(chunk) * 51'(ccs_pkg::LCG_MUL);

  always_comb begin
    case (ph_r)
      2'd0:    part = prod[SW-1:0];
      2'd1:    part = {prod[SW-17:0], 16'd0};
      default: part = {prod[SW-33:0], 32'd0};
    endcase
  end

  assign acc_sum = acc_r + part;
  assign last    = busy_r && (ph_r == 2'd2);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    ph_nxt    = ph_r;
    busy_nxt  = busy_r;
    if (ctl.load) begin
      state_nxt = seed;
    end else if (ctl.step) begin
      acc_nxt  = '0;
      ph_nxt   = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_sum;
      ph_nxt  = ph_r + 2'd1;
      if (last) begin
        state_nxt = acc_sum + ccs_pkg::LCG_ADD;
        busy_nxt  = 1'b0;
      end
    end
  end

  assign sts.done  = last;
  assign sts.state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccs_pkg::SEED_RST;
      busy_r  <= 1'b0;
      ph_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      ph_r    <= ph_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

@@ sv/ccs_chk.sv @@
// Port-level checker for the categorical CDF sampler, bound to the top level.
// Depends on ccs_pkg and on the port list of categorical_cdf_sampler_top.
`default_nettype none

module ccs_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ccs_pkg::out_data_t out_data,
  input wire logic               pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ccs_pkg::ST_SAMPLE |-> out_data.sample_column == '0)
    else $error("sample column set on a result without a sample");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again before the previous command finished");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port not ready");

endmodule

bind categorical_cdf_sampler_top ccs_chk u_ccs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire
